// ===== hw/rtl/sfr_pkg.sv =====
// Shared constants and types for the sensor frame receiver.
`default_nettype none

package sfr_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned StoreAw    = $clog2(FrameBytes);

  localparam logic [7:0] StartMark  = 8'hFF;
  localparam logic [7:0] KindReply  = 8'h86;
  localparam logic [7:0] KindUpload = 8'h04;
  localparam logic [7:0] HighMask   = 8'h1F;
  localparam logic [7:0] FaultBit   = 8'h80;

  // fill count and store index share one width: the count reaches FrameBytes
  localparam logic [StoreAw-1:0] FillFull  = StoreAw'(FrameBytes);
  localparam logic [StoreAw-1:0] FillLast  = StoreAw'(FrameBytes - 1);
  localparam logic [StoreAw-1:0] SumFirst  = StoreAw'(1);
  localparam logic [StoreAw-1:0] SumLast   = StoreAw'(FrameBytes - 2);

  localparam int unsigned ConcW = 13;

  typedef logic [FrameBytes-1:0][7:0] frame_t;

  typedef struct packed {
    logic               append;
    logic               shift;
    logic [StoreAw-1:0] wr_addr;
    logic [7:0]         wr_data;
  } store_op_t;

  typedef struct packed {
    logic             load;
    logic [ConcW-1:0] conc;
    logic             fault;
    logic             kind;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfr_store.sv =====
// Nine-byte frame store: append at the fill point, shift toward the head.
`default_nettype none

module sfr_store import sfr_pkg::*; (
  input  wire logic      clk_i,
  input  wire store_op_t op_i,
  output frame_t         frame_o
);

  frame_t frame_q;

  // payload only: entries are never read before being written
  always_ff @(posedge clk_i) begin
    if (op_i.append) begin
      frame_q[op_i.wr_addr] <= op_i.wr_data;
    end else if (op_i.shift) begin
      for (int i = 0; i < FrameBytes - 1; i++) begin
        frame_q[i] <= frame_q[i+1];
      end
    end
  end

  assign frame_o = frame_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_ctrl.sv =====
// Sequencer: byte intake, serial checksum over one accumulator adder, resync shifting.
`default_nettype none

module sfr_ctrl import sfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            in_stall_o,
  input  wire logic       out_free_i,
  input  wire frame_t     frame_i,
  output store_op_t       op_o,
  output result_t         res_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSum   = 2'd1;
  localparam logic [1:0] StCheck = 2'd2;
  localparam logic [1:0] StDrop  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [StoreAw-1:0] fill_q, fill_d;
  logic [StoreAw-1:0] idx_q, idx_d;
  logic [7:0]         acc_q, acc_d;

  logic               take;
  logic [7:0]         rd_byte;
  logic [7:0]         chk_sum;
  logic               kind_ok;
  logic               frame_ok;
  logic               reply;
  logic [7:0]         hi_byte;
  logic [7:0]         lo_byte;
  logic [7:0]         hi_masked;
  logic [StoreAw-1:0] fill_dec;

  assign in_stall_o = (state_q != StIdle);
  assign take       = in_valid_i && !in_stall_o;

  // accumulator adder: one store byte per cycle into the checksum
  assign rd_byte  = frame_i[idx_q];
  assign chk_sum  = acc_q + frame_i[FrameBytes-1];
  assign kind_ok  = (frame_i[1] == KindReply) || (frame_i[1] == KindUpload);
  assign frame_ok = kind_ok && (chk_sum == 8'd0);
  assign fill_dec = fill_q - StoreAw'(1);

  assign reply     = (frame_i[1] == KindReply);
  assign hi_byte   = reply ? frame_i[2] : frame_i[4];
  assign lo_byte   = reply ? frame_i[3] : frame_i[5];
  assign hi_masked = hi_byte & HighMask;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    acc_d   = acc_q;

    op_o.append  = 1'b0;
    op_o.shift   = 1'b0;
    op_o.wr_addr = fill_q;
    op_o.wr_data = rx_byte_i;

    res_o.load  = 1'b0;
    res_o.conc  = {hi_masked[4:0], lo_byte};
    res_o.fault = |(hi_byte & FaultBit);
    res_o.kind  = !reply;

    unique case (state_q)
      StIdle: begin
        // drop stray bytes until a start mark opens a frame
        if (take && !(fill_q == '0 && rx_byte_i != StartMark)) begin
          op_o.append = 1'b1;
          fill_d      = fill_q + StoreAw'(1);
          if (fill_q == FillLast) begin
            state_d = StSum;
            idx_d   = SumFirst;
            acc_d   = 8'd0;
          end
        end
      end
      StSum: begin
        acc_d = acc_q + rd_byte;
        if (idx_q == SumLast) begin
          state_d = StCheck;
        end else begin
          idx_d = idx_q + StoreAw'(1);
        end
      end
      StCheck: begin
        if (!frame_ok) begin
          state_d = StDrop;
        end else if (out_free_i) begin
          // hold here while the previous result still waits
          res_o.load = 1'b1;
          fill_d     = '0;
          state_d    = StIdle;
        end
      end
      StDrop: begin
        op_o.shift = 1'b1;
        fill_d     = fill_dec;
        if (fill_dec == '0 || frame_i[1] == StartMark) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      idx_q   <= SumFirst;
      acc_q   <= 8'd0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill count beyond frame length");

  a_sum_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSum || state_q == StCheck) |-> fill_q == FillFull)
    else $error("checksum pass on a partial frame");

  a_load_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.load |-> (state_q == StCheck && out_free_i && kind_ok))
    else $error("result loaded outside a passing check");

  a_drop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDrop |=> fill_q == $past(fill_dec))
    else $error("drop step did not shorten the store");

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_frame_receiver.sv =====
// Top level of the sensor frame receiver: store, sequencer and result register.
// Timing: after a valid frame's last byte beat the sequencer steps through StSum and StCheck, and
//   the result is registered from StCheck, which holds while an earlier result beat is still stalled.
// Throughput: one byte beat per cycle up to the ninth, which holds off input through the checksum
//   adds on the one 8-bit accumulator adder and the check; resync after a bad frame adds StDrop steps.
// Reset: rst_ni clears the sequencer, fill count and result valid; store bytes are not reset.
`default_nettype none

module sensor_frame_receiver import sfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ConcW-1:0]      co_tenths_ppm_o,
  output logic                  fault_flag_o,
  output logic                  frame_kind_o
);

  store_op_t        op;
  frame_t           frame;
  result_t          res;
  logic             out_free;

  logic             out_valid_q;
  logic [ConcW-1:0] conc_q;
  logic             fault_q;
  logic             kind_q;

  // The result register frees when empty or when its beat is taken this cycle,
  // so a passing check waits only while a stalled beat still sits in the register.
  assign out_free = !out_valid_q || !out_stall_i;

  sfr_store u_store (
    .clk_i   (clk_i),
    .op_i    (op),
    .frame_o (frame)
  );

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .frame_i    (frame),
    .op_o       (op),
    .res_o      (res)
  );

  // Advance the valid flag: set on a loaded result, clear when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload while stalled; the sequencer only loads when the register is free.
  always_ff @(posedge clk_i) begin
    if (res.load) begin
      conc_q  <= res.conc;
      fault_q <= res.fault;
      kind_q  <= res.kind;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign co_tenths_ppm_o = conc_q;
  assign fault_flag_o    = fault_q;
  assign frame_kind_o    = kind_q;

endmodule

`default_nettype wire

// ===== tb/sv/sfr_frame_checker.sv =====
// Frame checker: tracks link bytes, predicts frame results and compares output beats.
module sfr_frame_checker import sfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ConcW-1:0] co_tenths_ppm_i,
  input  logic             fault_flag_i,
  input  logic             frame_kind_i,
  output int               fail_count_o,
  output int               results_due_o
);

  typedef struct packed {
    logic [ConcW-1:0] conc;
    logic             fault;
    logic             kind;
  } frame_result_t;

  logic [7:0]    held_bytes [FrameBytes];
  int            held_count;
  frame_result_t due_results [$];
  int            fails;

  assign fail_count_o = fails;

  // Append one byte to the frame store and queue a result when a good frame completes.
  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0]    sum;
    logic [7:0]    want_chk;
    logic [7:0]    hi;
    logic [7:0]    lo;
    logic [7:0]    hi_m;
    logic          reply;
    logic          kind_ok;
    frame_result_t res;
    if (held_count >= FrameBytes) held_count = 0;
    if (held_count == 0 && b != StartMark) return;
    held_bytes[held_count] = b;
    held_count++;
    if (held_count < FrameBytes) return;
    sum = 8'h00;
    for (int i = 1; i < FrameBytes - 1; i++) sum = sum + held_bytes[i];
    want_chk = 8'h00 - sum;
    kind_ok = (held_bytes[1] == KindReply) || (held_bytes[1] == KindUpload);
    if (!kind_ok || held_bytes[FrameBytes-1] != want_chk) begin
      // resync: drop the leading byte, then keep dropping until a start mark leads
      do begin
        held_count--;
        for (int i = 0; i < held_count; i++) held_bytes[i] = held_bytes[i+1];
      end while (held_count > 0 && held_bytes[0] != StartMark);
      return;
    end
    reply = (held_bytes[1] == KindReply);
    hi = reply ? held_bytes[2] : held_bytes[4];
    lo = reply ? held_bytes[3] : held_bytes[5];
    hi_m = hi & HighMask;
    res.conc  = {hi_m[4:0], lo};
    res.fault = (hi & FaultBit) != 8'h00;
    res.kind  = !reply;
    held_count = 0;
    due_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      held_count = 0;
      due_results.delete();
      fails = 0;
      results_due_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result beat with no frame pending: co_tenths_ppm %0d", co_tenths_ppm_i);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (co_tenths_ppm_i !== want.conc) begin
            $error("co_tenths_ppm: expected %0d, got %0d", want.conc, co_tenths_ppm_i);
            fails++;
          end
          if (fault_flag_i !== want.fault) begin
            $error("fault_flag: expected %0d, got %0d", want.fault, fault_flag_i);
            fails++;
          end
          if (frame_kind_i !== want.kind) begin
            $error("frame_kind: expected %0d, got %0d", want.kind, frame_kind_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) absorb_byte(rx_byte_i);
      results_due_o = due_results.size();
    end
  end

endmodule

// ===== tb/sv/sensor_frame_receiver_tb.sv =====
// Testbench top: clock, reset, byte stimulus, result backpressure and the final verdict.
module sensor_frame_receiver_tb;
  import sfr_pkg::*;

  // Ways to damage a frame on its way to the receiver.
  typedef enum int {
    FlawNone,
    FlawSum,
    FlawKind,
    FlawMarks,
    FlawShort
  } flaw_e;

  localparam int TotalBeats = 970;

  logic             clk_i;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [7:0]       rx_byte       = 8'h00;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [ConcW-1:0] co_tenths_ppm;
  logic             fault_flag;
  logic             frame_kind;

  int          mismatch_total;
  int          results_due;
  int          beats_sent = 0;
  int unsigned cycle_cnt  = 0;

  sensor_frame_receiver u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .co_tenths_ppm_o (co_tenths_ppm),
    .fault_flag_o    (fault_flag),
    .frame_kind_o    (frame_kind)
  );

  sfr_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .co_tenths_ppm_i (co_tenths_ppm),
    .fault_flag_i    (fault_flag),
    .frame_kind_i    (frame_kind),
    .fail_count_o    (mismatch_total),
    .results_due_o   (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Backpressure on the result side: stall at random, with a quiet
  // window in the middle of the run where every result beat goes straight through.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= 600 && cycle_cnt < 1200) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 6);
    end
  end

  // Drive one byte beat and hold it until the receiver takes it. A short idle gap
  // may come first, except inside the no-idle window of beats.
  task automatic push_byte(input logic [7:0] b);
    if (!(beats_sent >= 400 && beats_sent < 600)) begin
      while ($urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    // stall is sampled as it stood at the edge, before the block updates it
    do @(posedge clk_i); while (in_stall);
    beats_sent++;
  endtask

  // Build a frame of the given kind carrying hi/lo, damage it as asked, then send it.
  task automatic send_frame(input logic upload, input logic [7:0] hi, input logic [7:0] lo,
                            input flaw_e flaw);
    logic [7:0] f [FrameBytes];
    logic [7:0] sum;
    int         marks;
    int         keep;
    f[0] = StartMark;
    f[1] = upload ? KindUpload : KindReply;
    for (int i = 2; i < FrameBytes - 1; i++) f[i] = 8'($urandom_range(255));
    if (upload) begin
      f[4] = hi;
      f[5] = lo;
    end else begin
      f[2] = hi;
      f[3] = lo;
    end
    sum = 8'h00;
    for (int i = 1; i < FrameBytes - 1; i++) sum = sum + f[i];
    f[FrameBytes-1] = 8'h00 - sum;
    keep = FrameBytes;
    case (flaw)
      FlawSum: begin
        f[FrameBytes-1] = f[FrameBytes-1] ^ 8'($urandom_range(1, 255));
      end
      FlawKind: begin
        f[1] = 8'($urandom_range(255));
        if (f[1] == KindReply || f[1] == KindUpload) f[1] = f[1] ^ 8'h01;
      end
      FlawMarks: begin
        // plant start marks inside the frame so resync has somewhere to land
        marks = $urandom_range(1, 3);
        for (int m = 0; m < marks; m++) f[$urandom_range(1, FrameBytes - 1)] = StartMark;
      end
      FlawShort: begin
        keep = $urandom_range(1, FrameBytes - 1);
      end
      default: ;
    endcase
    for (int i = 0; i < keep; i++) push_byte(f[i]);
  endtask

  // Pick a concentration byte, leaning on the extremes now and then.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int    r;
    int    n;
    flaw_e flaw;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: a dropped byte on an empty store, a reply at full scale with the
    // fault bit and the ignored high bits set, an upload reading zero and a stray byte.
    push_byte(8'h00);
    send_frame(1'b0, 8'hFF, 8'hFF, FlawNone);
    send_frame(1'b1, 8'h00, 8'h00, FlawNone);
    push_byte(8'h7E);

    // Random: mostly good frames, the rest damaged frames and line noise.
    while (beats_sent < TotalBeats) begin
      r = $urandom_range(99);
      if (r < 66) flaw = FlawNone;
      else if (r < 74) flaw = FlawSum;
      else if (r < 80) flaw = FlawKind;
      else if (r < 86) flaw = FlawMarks;
      else if (r < 92) flaw = FlawShort;
      else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(255)));
        continue;
      end
      send_frame(1'($urandom_range(1)), pick_byte(), pick_byte(), flaw);
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then let resync and latency settle.
    while (results_due != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);

    if (mismatch_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
